[sv/cil_pkg.sv]
// Shared types and constants for the compacting indexed list.
// Used by the entry cells, the top level and the port checker.
`default_nettype none
package cil_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int WORD_W     = 32;
  localparam int VALUE_W    = 32;
  localparam logic [CNT_W-1:0] INIT_CAP = CNT_W'(4);

  typedef enum logic [1:0] {
    CMD_APPEND    = 2'd0,
    CMD_READ      = 2'd1,
    CMD_OVERWRITE = 2'd2,
    CMD_DELETE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Broadcast to every cell in the row for one command.
  typedef struct packed {
    logic              append_ok;
    logic              write_ok;
    logic              delete_ok;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  count;
  } cell_ctl_t;

endpackage
`default_nettype wire

[sv/cil_cell.sv]
// One entry cell of the list row: holds a word, takes a new one on write
// or its upper neighbor's word on a compacting delete. Depends on cil_pkg.
`default_nettype none
module cil_cell import cil_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_W,
  parameter int POS         = 0
) (
  input  wire logic                   clk_i,
  input  wire cell_ctl_t              ctl_i,
  input  wire logic [VALUE_WIDTH-1:0] wr_value_i,
  input  wire logic [VALUE_WIDTH-1:0] next_i,
  output logic      [VALUE_WIDTH-1:0] value_o
);

  localparam logic [CNT_W-1:0] PosC = CNT_W'(POS);

  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic                   write_here;
  logic                   shift_here;

  assign write_here = (ctl_i.append_ok && (ctl_i.count == PosC)) ||
                      (ctl_i.write_ok && (CNT_W'(ctl_i.idx) == PosC));
  // close the gap: every cell at or above the deleted slot takes its neighbor
  assign shift_here = ctl_i.delete_ok && (PosC >= CNT_W'(ctl_i.idx));

  always_comb begin
    priority if (write_here) begin
      value_d = wr_value_i;
    end else if (shift_here) begin
      value_d = next_i;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
`default_nettype wire

[sv/compacting_indexed_list.sv]
// Top level of the compacting indexed list: a row of entry cells plus the
// count and capacity registers. Depends on cil_pkg and cil_cell.
//
// The list takes one command per clock: busy_o stays low, and each command
// gives its result with done_o in the cycle after the transfer. Every entry
// sits in its own cell, so a delete moves all later entries down in that
// same cycle. A read selects the indexed cell directly. Capacity starts at
// four, doubles (up to the list depth) on an append when the count equals
// the capacity, and halves when a delete leaves a nonzero count equal to a
// quarter of it. Results cannot be held off; the count and capacity ports
// always show the state after the last command.
`default_nettype none
module compacting_indexed_list import cil_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_W
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        command_i,
  input  wire logic [IDX_W-1:0]  index_i,
  input  wire logic [WORD_W-1:0] value_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [WORD_W-1:0]      read_value_o,
  output logic [CNT_W-1:0]       entry_count_o,
  output logic [CNT_W-1:0]       logical_capacity_o
);

  localparam logic [CNT_W-1:0] DepthC = CNT_W'(LIST_DEPTH);

  logic                   xfer;
  logic                   in_range;
  logic                   is_full;
  cell_ctl_t              ctl;
  logic [VALUE_WIDTH-1:0] wr_value;
  logic [VALUE_WIDTH-1:0] cell_value [LIST_DEPTH];

  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  cap_q, cap_d;
  logic [CNT_W:0]    grown;
  logic [CNT_W-1:0]  count_less;
  logic              done_q;
  logic [1:0]        status_q, status_d;
  logic [WORD_W-1:0] read_q, read_d;

  assign busy_o   = 1'b0;
  assign xfer     = start_i && !busy_o;
  assign in_range = CNT_W'(index_i) < count_q;
  assign is_full  = count_q >= DepthC;
  assign wr_value = VALUE_WIDTH'(value_i);

  always_comb begin
    ctl.append_ok = xfer && (cmd_e'(command_i) == CMD_APPEND) && !is_full;
    ctl.write_ok  = xfer && (cmd_e'(command_i) == CMD_OVERWRITE) && in_range;
    ctl.delete_ok = xfer && (cmd_e'(command_i) == CMD_DELETE) && in_range;
    ctl.idx       = index_i;
    ctl.count     = count_q;
  end

  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    logic [VALUE_WIDTH-1:0] next_value;
    if (k == LIST_DEPTH - 1) begin : g_last
      assign next_value = cell_value[k];
    end else begin : g_mid
      assign next_value = cell_value[k+1];
    end
    cil_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .POS         (k)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .wr_value_i (wr_value),
      .next_i     (next_value),
      .value_o    (cell_value[k])
    );
  end

  assign grown      = {1'b0, cap_q} << 1;
  assign count_less = count_q - CNT_W'(1);

  always_comb begin
    count_d  = count_q;
    cap_d    = cap_q;
    status_d = ST_OK;
    read_d   = '0;
    unique case (cmd_e'(command_i))
      CMD_APPEND: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
          if (cap_q == count_q) begin
            cap_d = (grown > (CNT_W+1)'(LIST_DEPTH)) ? DepthC : grown[CNT_W-1:0];
          end
        end
      end
      CMD_READ: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else begin
          read_d = WORD_W'(cell_value[index_i]);
        end
      end
      CMD_OVERWRITE: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end
      end
      CMD_DELETE: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else begin
          count_d = count_less;
          // shrink once the list drops to a quarter of capacity
          if ((count_less != '0) && (count_less == (cap_q >> 2))) begin
            cap_d = cap_q >> 1;
          end
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= INIT_CAP;
      done_q  <= 1'b0;
    end else begin
      done_q <= xfer;
      if (xfer) begin
        count_q <= count_d;
        cap_q   <= cap_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      status_q <= status_d;
      read_q   <= read_d;
    end
  end

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign read_value_o       = read_q;
  assign entry_count_o      = count_q;
  assign logical_capacity_o = cap_q;

endmodule
`default_nettype wire

[sv/cil_checker.sv]
// Port-level checks for the compacting indexed list, bound to the top level.
// Depends on cil_pkg.
`default_nettype none
module cil_checker import cil_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire logic              done_o,
  input wire logic [1:0]        status_o,
  input wire logic [WORD_W-1:0] read_value_o,
  input wire logic [CNT_W-1:0]  entry_count_o,
  input wire logic [CNT_W-1:0]  logical_capacity_o
);

  // every transfer gives exactly one result in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("transfer without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result without transfer");

  a_cap_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (logical_capacity_o >= entry_count_o) &&
               (entry_count_o <= CNT_W'(LIST_DEPTH)))
    else $error("count exceeds capacity or depth");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (read_value_o == '0))
    else $error("nonzero read value on error");

endmodule

bind compacting_indexed_list cil_checker u_cil_checker (.*);
`default_nettype wire
